// ----- hdl/stls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stls_pkg
// Shared types and constants for the segment timeline sequencer.
// ----------------------------------------------------------------------------
package stls_pkg;

    localparam int CMD_W       = 3;
    localparam int INDEX_W     = 6;
    localparam int LOAD_STEP_W = 16;
    localparam int ROW_COUNT_W = 7;
    localparam int STATUS_W    = 3;
    localparam int STEP_OUT_W  = 17;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_TICK   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED   = 3'd0,
        ST_MISSING   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NONE      = 3'd4
    } start_status_t;

    // configuration register indexes
    localparam logic CFG_TABLE_PRESENT = 1'b0;
    localparam logic CFG_ROW_COUNT     = 1'b1;

    typedef struct packed {
        cmd_t                   cmd;
        logic [INDEX_W-1:0]     row_index;
        logic [LOAD_STEP_W-1:0] row_total_step;
        logic                   row_suspend;
    } item_t;

    typedef struct packed {
        logic dispatch;
        logic running;
        logic held;
        logic first_step;
        logic final_step_of_segment;
        logic final_segment;
        logic final_step_overall;
    } res_flags_t;

endpackage

// ----- hdl/segment_timeline_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_timeline_sequencer_unit
// Walks a table of timeline segments under load/start/stop/pause/resume/tick.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid/in_stall with cmd, row_index, row_total_step
//   and row_suspend. Result channel: out_valid/out_stall, one result per
//   request, in request order.
//   Config: cfg_we/cfg_index/cfg_data write table_present (index 0) and
//   row_count (index 1); write only while no request is in flight.
//   The request passes through the input register, then the result register.
//   Throughput: one request per cycle while the result is not stalled; the
//   row store is read ahead at the next segment so a tick that moves on
//   never waits.
//   A stalled result holds; the input register still takes one more request,
//   after which in_stall rises until the result is taken.
//   Reset: sequencer idle, step -1, config registers cleared. Table rows are
//   undefined until loaded; no clearing pass is made.
// ----------------------------------------------------------------------------
module segment_timeline_sequencer_unit #(
    parameter int MAX_ROWS  = 64,
    parameter int STEP_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic                                      cfg_index,
    input  logic [stls_pkg::ROW_COUNT_W-1:0]          cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [stls_pkg::CMD_W-1:0]                cmd,
    input  logic [stls_pkg::INDEX_W-1:0]              row_index,
    input  logic [stls_pkg::LOAD_STEP_W-1:0]          row_total_step,
    input  logic                                      row_suspend,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [stls_pkg::STATUS_W-1:0]             start_status,
    output logic                                      dispatch,
    output logic                                      is_running,
    output logic                                      is_held,
    output logic [stls_pkg::INDEX_W-1:0]              segment_index,
    output logic signed [stls_pkg::STEP_OUT_W-1:0]    segment_step,
    output logic                                      first_step,
    output logic                                      final_step_of_segment,
    output logic                                      final_segment,
    output logic                                      final_step_overall
);

    localparam int IW = $clog2(MAX_ROWS);
    localparam int SW = STEP_BITS;

    // configuration
    logic                               table_present_reg;
    logic [stls_pkg::ROW_COUNT_W-1:0]   row_count_reg;

    // input register
    logic                               s1_valid_reg;
    stls_pkg::item_t                    item_reg;

    // sequencer state
    logic                               active_reg;
    logic                               paused_reg;
    logic [IW-1:0]                      idx_reg;
    logic signed [SW:0]                 step_reg;
    logic [SW-1:0]                      cur_total_reg;
    logic                               cur_susp_reg;

    // result register
    logic                               out_valid_reg;
    stls_pkg::start_status_t            status_reg;
    stls_pkg::res_flags_t               flags_reg;
    logic [stls_pkg::INDEX_W-1:0]       seg_index_reg;
    logic signed [stls_pkg::STEP_OUT_W-1:0] seg_step_reg;

    logic                               in_acc;
    logic                               res_free;
    logic                               s1_go;
    logic [IW-1:0]                      idx_commit;

    logic                               nx_active;
    logic                               nx_paused;
    logic [IW-1:0]                      nx_idx;
    logic signed [SW:0]                 nx_step;
    logic [SW-1:0]                      nx_cur_total;
    logic                               nx_cur_susp;
    stls_pkg::start_status_t            nx_status;
    stls_pkg::res_flags_t               nx_flags;
    logic                               nx_we;
    logic [IW-1:0]                      nx_waddr;
    logic [SW:0]                        nx_wrow;
    logic [SW:0]                        look_row;
    logic [SW:0]                        ahead_row;

    assign res_free   = !out_valid_reg || !out_stall;
    assign s1_go      = s1_valid_reg && res_free;
    assign in_stall   = s1_valid_reg && !res_free;
    assign in_acc     = in_valid && !in_stall;
    assign idx_commit = s1_go ? nx_idx : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_present_reg <= 1'b0;
            row_count_reg     <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == stls_pkg::CFG_TABLE_PRESENT)
            begin
                table_present_reg <= cfg_data[0];
            end
            else
            begin
                row_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            paused_reg    <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '1;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
                active_reg    <= nx_active;
                paused_reg    <= nx_paused;
                idx_reg       <= nx_idx;
                step_reg      <= nx_step;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= '{cmd:            stls_pkg::cmd_t'(cmd),
                          row_index:      row_index,
                          row_total_step: row_total_step,
                          row_suspend:    row_suspend};
        end
        if (s1_go)
        begin
            cur_total_reg <= nx_cur_total;
            cur_susp_reg  <= nx_cur_susp;
            status_reg    <= nx_status;
            flags_reg     <= nx_flags;
            seg_index_reg <= nx_active ? stls_pkg::INDEX_W'(nx_idx) : '0;
            seg_step_reg  <= stls_pkg::STEP_OUT_W'(nx_step);
        end
    end

    stls_table #(
        .MAX_ROWS  (MAX_ROWS),
        .STEP_BITS (STEP_BITS)
    ) u_table (
        .clk        (clk),
        .we         (s1_go && nx_we),
        .waddr      (nx_waddr),
        .wrow       (nx_wrow),
        .look_en    (in_acc),
        .look_addr  (IW'(row_index)),
        .look_row   (look_row),
        .ahead_addr (idx_commit + IW'(1)),
        .ahead_row  (ahead_row)
    );

    stls_next #(
        .MAX_ROWS  (MAX_ROWS),
        .STEP_BITS (STEP_BITS)
    ) u_next (
        .item          (item_reg),
        .table_present (table_present_reg),
        .row_count     (row_count_reg),
        .active        (active_reg),
        .paused        (paused_reg),
        .idx           (idx_reg),
        .step          (step_reg),
        .cur_total     (cur_total_reg),
        .cur_susp      (cur_susp_reg),
        .look_row      (look_row),
        .ahead_row     (ahead_row),
        .active_n      (nx_active),
        .paused_n      (nx_paused),
        .idx_n         (nx_idx),
        .step_n        (nx_step),
        .cur_total_n   (nx_cur_total),
        .cur_susp_n    (nx_cur_susp),
        .status        (nx_status),
        .flags         (nx_flags),
        .we            (nx_we),
        .waddr         (nx_waddr),
        .wrow          (nx_wrow)
    );

    assign out_valid             = out_valid_reg;
    assign start_status          = status_reg;
    assign dispatch              = flags_reg.dispatch;
    assign is_running            = flags_reg.running;
    assign is_held               = flags_reg.held;
    assign segment_index         = seg_index_reg;
    assign segment_step          = seg_step_reg;
    assign first_step            = flags_reg.first_step;
    assign final_step_of_segment = flags_reg.final_step_of_segment;
    assign final_segment         = flags_reg.final_segment;
    assign final_step_overall    = flags_reg.final_step_overall;

`ifndef NO_ASSERTIONS
    a_held_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        paused_reg |-> active_reg)
        else $error("paused while sequencer inactive");

    a_dispatch_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dispatch) |-> (is_running && !is_held))
        else $error("dispatch without an active unpaused sequencer");

    a_overall_implies_parts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_step_overall) |-> (final_segment && final_step_of_segment))
        else $error("final step overall without its parts");

    a_start_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (start_status == stls_pkg::ST_STARTED))
            |-> (is_running && (segment_step == '1)))
        else $error("successful start did not leave step at -1");
`endif

endmodule

// ----- hdl/stls_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stls_table
// Segment row store: one write port, two registered read ports with
// write-through so a read in the cycle of a write sees the new row.
// ----------------------------------------------------------------------------
module stls_table #(
    parameter int MAX_ROWS  = 64,
    parameter int STEP_BITS = 16
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(MAX_ROWS)-1:0] waddr,
    input  logic [STEP_BITS:0]          wrow,
    input  logic                        look_en,
    input  logic [$clog2(MAX_ROWS)-1:0] look_addr,
    output logic [STEP_BITS:0]          look_row,
    input  logic [$clog2(MAX_ROWS)-1:0] ahead_addr,
    output logic [STEP_BITS:0]          ahead_row
);

    // row word: {suspend, total}
    logic [STEP_BITS:0] row_mem_reg [MAX_ROWS];
    logic [STEP_BITS:0] look_row_reg;
    logic [STEP_BITS:0] ahead_row_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem_reg[waddr] <= wrow;
        end
        if (look_en)
        begin
            if (we && (waddr == look_addr))
            begin
                look_row_reg <= wrow;
            end
            else
            begin
                look_row_reg <= row_mem_reg[look_addr];
            end
        end
        if (we && (waddr == ahead_addr))
        begin
            ahead_row_reg <= wrow;
        end
        else
        begin
            ahead_row_reg <= row_mem_reg[ahead_addr];
        end
    end

    assign look_row  = look_row_reg;
    assign ahead_row = ahead_row_reg;

endmodule

// ----- hdl/stls_next.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stls_next
// Next-state and result logic for one request of the sequencer.
// ----------------------------------------------------------------------------
module stls_next #(
    parameter int MAX_ROWS  = 64,
    parameter int STEP_BITS = 16
) (
    input  stls_pkg::item_t                        item,
    input  logic                                   table_present,
    input  logic [stls_pkg::ROW_COUNT_W-1:0]       row_count,
    input  logic                                   active,
    input  logic                                   paused,
    input  logic [$clog2(MAX_ROWS)-1:0]            idx,
    input  logic signed [STEP_BITS:0]              step,
    input  logic [STEP_BITS-1:0]                   cur_total,
    input  logic                                   cur_susp,
    input  logic [STEP_BITS:0]                     look_row,
    input  logic [STEP_BITS:0]                     ahead_row,
    output logic                                   active_n,
    output logic                                   paused_n,
    output logic [$clog2(MAX_ROWS)-1:0]            idx_n,
    output logic signed [STEP_BITS:0]              step_n,
    output logic [STEP_BITS-1:0]                   cur_total_n,
    output logic                                   cur_susp_n,
    output stls_pkg::start_status_t                status,
    output stls_pkg::res_flags_t                   flags,
    output logic                                   we,
    output logic [$clog2(MAX_ROWS)-1:0]            waddr,
    output logic [STEP_BITS:0]                     wrow
);

    localparam int IW = $clog2(MAX_ROWS);
    localparam int SW = STEP_BITS;
    localparam int CW = ((IW > stls_pkg::ROW_COUNT_W) ? IW : stls_pkg::ROW_COUNT_W) + 1;
    localparam logic [CW-1:0] MaxRowsCw = CW'(MAX_ROWS);

    logic [CW-1:0]       rows;
    logic [CW-1:0]       idx_ext;
    logic [CW-1:0]       idx_n_ext;
    logic [CW-1:0]       row_index_ext;
    logic [SW-1:0]       load_total;
    logic signed [SW:0]  step_inc;
    logic [SW:0]         step_n_inc;
    logic                dispatch;
    logic                in_range;
    logic                seg_last;
    logic                last_seg;

    assign rows = (CW'(row_count) > MaxRowsCw) ? MaxRowsCw : CW'(row_count);
    assign idx_ext       = CW'(idx);
    assign row_index_ext = CW'(item.row_index);
    assign load_total    = SW'(item.row_total_step);
    assign step_inc      = step + (SW+1)'(1);

    assign waddr = IW'(item.row_index);
    assign wrow  = {item.row_suspend, load_total};

    always_comb
    begin
        active_n    = active;
        paused_n    = paused;
        idx_n       = idx;
        step_n      = step;
        cur_total_n = cur_total;
        cur_susp_n  = cur_susp;
        status      = stls_pkg::ST_NONE;
        dispatch    = 1'b0;
        we          = 1'b0;
        unique case (item.cmd)
            stls_pkg::CMD_LOAD:
            begin
                if (row_index_ext < MaxRowsCw)
                begin
                    we = 1'b1;
                    // keep the shadow of the current row coherent
                    if (waddr == idx)
                    begin
                        cur_total_n = load_total;
                        cur_susp_n  = item.row_suspend;
                    end
                end
            end
            stls_pkg::CMD_START:
            begin
                active_n = 1'b0;
                paused_n = 1'b0;
                idx_n    = '0;
                step_n   = '1;
                priority if (!table_present)
                begin
                    status = stls_pkg::ST_MISSING;
                end
                else if (rows == '0)
                begin
                    status = stls_pkg::ST_EMPTY;
                end
                else if (row_index_ext >= rows)
                begin
                    status = stls_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    status      = stls_pkg::ST_STARTED;
                    active_n    = 1'b1;
                    idx_n       = waddr;
                    cur_total_n = look_row[SW-1:0];
                    cur_susp_n  = look_row[SW];
                end
            end
            stls_pkg::CMD_STOP:
            begin
                active_n = 1'b0;
                paused_n = 1'b0;
                idx_n    = '0;
                step_n   = '1;
            end
            stls_pkg::CMD_PAUSE:
            begin
                if (active)
                begin
                    paused_n = 1'b1;
                end
            end
            stls_pkg::CMD_RESUME:
            begin
                paused_n = 1'b0;
            end
            stls_pkg::CMD_TICK:
            begin
                if (active)
                begin
                    priority if (paused)
                    begin
                        // held: only -1 -> 0 -> 1
                        if (step[SW] || (step == '0))
                        begin
                            step_n = step_inc;
                        end
                    end
                    else if (idx_ext >= rows)
                    begin
                        active_n = 1'b0;
                        paused_n = 1'b0;
                        idx_n    = '0;
                        step_n   = '1;
                    end
                    else if ($unsigned(step_inc) < {1'b0, cur_total})
                    begin
                        step_n   = step_inc;
                        dispatch = 1'b1;
                    end
                    else if (cur_susp || ((idx_ext + CW'(1)) >= rows))
                    begin
                        active_n = 1'b0;
                        paused_n = 1'b0;
                        idx_n    = '0;
                        step_n   = '1;
                    end
                    else
                    begin
                        idx_n       = idx + IW'(1);
                        step_n      = '0;
                        cur_total_n = ahead_row[SW-1:0];
                        cur_susp_n  = ahead_row[SW];
                        dispatch    = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign idx_n_ext  = CW'(idx_n);
    assign step_n_inc = step_n + (SW+1)'(1);
    assign in_range   = active_n && (idx_n_ext < rows);
    assign seg_last   = in_range && (step_n_inc == {1'b0, cur_total_n});
    assign last_seg   = active_n && !paused_n && ((idx_n_ext + CW'(1)) == rows);

    always_comb
    begin
        flags.dispatch              = dispatch;
        flags.running               = active_n;
        flags.held                  = paused_n;
        flags.first_step            = in_range && (step_n == '0);
        flags.final_step_of_segment = seg_last;
        flags.final_segment         = last_seg;
        flags.final_step_overall    = last_seg && seg_last;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment timeline sequencer.
// Drives load/start/stop/pause/resume/tick requests and checks each result
// field against an in-bench model of the cursor, the row table and the flags.
// Directed tests come first, then random traffic. Both channels idle at
// random except in one steady phase of the random traffic.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_ROWS      = 64;
    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 16;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int STEADY_PHASE    = 3;

    // command codes the block does not define; they must change nothing
    localparam logic [stls_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [stls_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    typedef struct {
        stls_pkg::start_status_t                status;
        logic [stls_pkg::INDEX_W-1:0]           index;
        logic signed [stls_pkg::STEP_OUT_W-1:0] step;
        stls_pkg::res_flags_t                   flags;
    } seq_result_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   cfg_we;
    logic                                   cfg_index;
    logic [stls_pkg::ROW_COUNT_W-1:0]       cfg_data;
    logic                                   in_valid;
    logic                                   in_stall;
    logic [stls_pkg::CMD_W-1:0]             cmd;
    logic [stls_pkg::INDEX_W-1:0]           row_index;
    logic [stls_pkg::LOAD_STEP_W-1:0]       row_total_step;
    logic                                   row_suspend;
    logic                                   out_valid;
    logic                                   out_stall;
    logic [stls_pkg::STATUS_W-1:0]          start_status;
    logic                                   dispatch;
    logic                                   is_running;
    logic                                   is_held;
    logic [stls_pkg::INDEX_W-1:0]           segment_index;
    logic signed [stls_pkg::STEP_OUT_W-1:0] segment_step;
    logic                                   first_step;
    logic                                   final_step_of_segment;
    logic                                   final_segment;
    logic                                   final_step_overall;

    // model state
    int  step_row [TABLE_ROWS];
    bit  suspend_row [TABLE_ROWS];
    int  cur_seg;
    int  cur_step;
    bit  seq_active;
    bit  seq_paused;
    bit  tbl_present;
    int  cfg_rows;

    seq_result_t pending_results [$];

    bit  steady;
    int  fail_count;
    int  sent_count;
    int  checked_count;
    int  started_count;
    int  dispatch_count;
    int  cfg_count;
    int  idle_cycles;

    segment_timeline_sequencer_unit u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .cmd                   (cmd),
        .row_index             (row_index),
        .row_total_step        (row_total_step),
        .row_suspend           (row_suspend),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .start_status          (start_status),
        .dispatch              (dispatch),
        .is_running            (is_running),
        .is_held               (is_held),
        .segment_index         (segment_index),
        .segment_step          (segment_step),
        .first_step            (first_step),
        .final_step_of_segment (final_step_of_segment),
        .final_segment         (final_segment),
        .final_step_overall    (final_step_overall)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic int rows_in_use();
        return (cfg_rows > TABLE_ROWS) ? TABLE_ROWS : cfg_rows;
    endfunction

    function automatic void halt_sequence();
        cur_seg    = 0;
        cur_step   = -1;
        seq_active = 1'b0;
        seq_paused = 1'b0;
    endfunction

    function automatic seq_result_t predict_result(
        input logic [stls_pkg::CMD_W-1:0]       op,
        input logic [stls_pkg::INDEX_W-1:0]     idx,
        input logic [stls_pkg::LOAD_STEP_W-1:0] steps,
        input logic                             susp);
        seq_result_t res;
        int          n;
        bit          in_range;
        bit          seg_last;
        bit          last_seg;
        res.status = stls_pkg::ST_NONE;
        res.flags  = '0;
        n = rows_in_use();
        case (op)
            stls_pkg::CMD_LOAD:
            begin
                step_row[idx]    = int'(steps);
                suspend_row[idx] = susp;
            end
            stls_pkg::CMD_START:
            begin
                // a start always stops first
                halt_sequence();
                if (!tbl_present)
                    res.status = stls_pkg::ST_MISSING;
                else if (n == 0)
                    res.status = stls_pkg::ST_EMPTY;
                else if (int'(idx) >= n)
                    res.status = stls_pkg::ST_NOT_FOUND;
                else
                begin
                    cur_seg    = int'(idx);
                    seq_active = 1'b1;
                    res.status = stls_pkg::ST_STARTED;
                end
            end
            stls_pkg::CMD_STOP:
                halt_sequence();
            stls_pkg::CMD_PAUSE:
                if (seq_active)
                    seq_paused = 1'b1;
            stls_pkg::CMD_RESUME:
                seq_paused = 1'b0;
            stls_pkg::CMD_TICK:
                if (seq_active)
                begin
                    if (seq_paused)
                    begin
                        // held: only -1 and 0 creep up
                        if (cur_step <= 0)
                            cur_step++;
                    end
                    else if (cur_seg >= n)
                        halt_sequence();
                    else
                    begin
                        cur_step++;
                        if (cur_step < step_row[cur_seg])
                            res.flags.dispatch = 1'b1;
                        else if (suspend_row[cur_seg] || cur_seg + 1 >= n)
                            halt_sequence();
                        else
                        begin
                            cur_seg++;
                            cur_step = 0;
                            res.flags.dispatch = 1'b1;
                        end
                    end
                end
            default: ;
        endcase

        in_range = seq_active && cur_seg < n;
        seg_last = in_range && cur_step == step_row[cur_seg] - 1;
        last_seg = seq_active && !seq_paused && cur_seg + 1 == n;

        res.index                       = seq_active ? stls_pkg::INDEX_W'(cur_seg) : '0;
        res.step                        = stls_pkg::STEP_OUT_W'(cur_step);
        res.flags.running               = seq_active;
        res.flags.held                  = seq_paused;
        res.flags.first_step            = in_range && cur_step == 0;
        res.flags.final_step_of_segment = seg_last;
        res.flags.final_segment         = last_seg;
        res.flags.final_step_overall    = last_seg && seg_last;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string field,
                                        input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        seq_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("start_status", want.status, start_status);
                check_field("dispatch", want.flags.dispatch, dispatch);
                check_field("is_running", want.flags.running, is_running);
                check_field("is_held", want.flags.held, is_held);
                check_field("segment_index", want.index, segment_index);
                check_field("segment_step", want.step, segment_step);
                check_field("first_step", want.flags.first_step, first_step);
                check_field("final_step_of_segment", want.flags.final_step_of_segment,
                            final_step_of_segment);
                check_field("final_segment", want.flags.final_segment, final_segment);
                check_field("final_step_overall", want.flags.final_step_overall,
                            final_step_overall);
                checked_count++;
                if (want.status == stls_pkg::ST_STARTED)
                    started_count++;
                if (want.flags.dispatch)
                    dispatch_count++;
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [stls_pkg::CMD_W-1:0]       op,
                                input logic [stls_pkg::INDEX_W-1:0]     idx,
                                input logic [stls_pkg::LOAD_STEP_W-1:0] steps,
                                input logic                             susp);
        seq_result_t res;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= op;
        row_index      <= idx;
        row_total_step <= steps;
        row_suspend    <= susp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_result(op, idx, steps, susp);
        pending_results.insert(pending_results.size(), res);
        sent_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input bit present, input int rows);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= stls_pkg::CFG_TABLE_PRESENT;
        cfg_data  <= stls_pkg::ROW_COUNT_W'(present);
        @(posedge clk);
        cfg_index <= stls_pkg::CFG_ROW_COUNT;
        cfg_data  <= stls_pkg::ROW_COUNT_W'(rows);
        @(posedge clk);
        cfg_we <= 1'b0;
        tbl_present = present;
        cfg_rows    = rows & 127;
        cfg_count++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // every row gets written before any start so no unloaded row is ever read
    task automatic fill_all_rows();
        for (int row = 0; row < TABLE_ROWS; row++)
            send_request(stls_pkg::CMD_LOAD, stls_pkg::INDEX_W'(row),
                         stls_pkg::LOAD_STEP_W'($urandom_range(1, 4)),
                         $urandom_range(0, 4) == 0);
    endtask

    task automatic test_start_status();
        set_config(1'b0, 0);
        send_request(stls_pkg::CMD_START, 6'd0, 16'd0, 1'b0);
        set_config(1'b1, 0);
        send_request(stls_pkg::CMD_START, 6'd0, 16'd0, 1'b0);
        set_config(1'b1, 5);
        send_request(stls_pkg::CMD_START, 6'd5, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_START, 6'd63, 16'd0, 1'b0);
        // above the table size, clamps to all rows
        set_config(1'b1, 127);
        send_request(stls_pkg::CMD_START, 6'd63, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_STOP, 6'd0, 16'd0, 1'b0);
    endtask

    task automatic test_field_extremes();
        send_request(stls_pkg::CMD_LOAD, 6'd63, 16'hFFFF, 1'b1);
        send_request(stls_pkg::CMD_LOAD, 6'd62, 16'h0000, 1'b0);
        send_request(stls_pkg::CMD_LOAD, 6'd61, 16'hAAAA, 1'b0);
        send_request(stls_pkg::CMD_LOAD, 6'd60, 16'h5555, 1'b1);
        // zero-length segment passes straight on to the next row
        send_request(stls_pkg::CMD_START, 6'd62, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_STOP, 6'd0, 16'd0, 1'b0);
    endtask

    task automatic test_pause_hold();
        set_config(1'b1, 4);
        send_request(stls_pkg::CMD_LOAD, 6'd0, 16'd2, 1'b0);
        send_request(stls_pkg::CMD_LOAD, 6'd1, 16'd0, 1'b1);
        send_request(stls_pkg::CMD_LOAD, 6'd2, 16'd1, 1'b0);
        send_request(stls_pkg::CMD_LOAD, 6'd3, 16'd2, 1'b0);
        send_request(stls_pkg::CMD_STOP, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_PAUSE, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_START, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_PAUSE, 6'd0, 16'd0, 1'b0);
        // held ticks: -1 -> 0 -> 1, then no further
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_RESUME, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        // row 1 carries the suspend flag
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
    endtask

    task automatic test_last_row();
        send_request(stls_pkg::CMD_START, 6'd2, 16'd0, 1'b0);
        repeat (4) send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
    endtask

    task automatic test_shrink_rows();
        send_request(stls_pkg::CMD_START, 6'd3, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
        set_config(1'b1, 2);
        send_request(stls_pkg::CMD_TICK, 6'd0, 16'd0, 1'b0);
    endtask

    task automatic test_unknown_cmds();
        set_config(1'b1, 4);
        send_request(stls_pkg::CMD_START, 6'd0, 16'd0, 1'b0);
        send_request(CMD_RSVD_6, 6'd63, 16'hFFFF, 1'b1);
        send_request(CMD_RSVD_7, 6'd0, 16'd0, 1'b0);
        send_request(stls_pkg::CMD_STOP, 6'd0, 16'd0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int                               r;
        int                               n;
        logic [stls_pkg::INDEX_W-1:0]     idx;
        logic [stls_pkg::LOAD_STEP_W-1:0] steps;
        logic                             susp;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 70)
                n = int'($urandom_range(1, 8));
            else if (r < 80)
                n = int'($urandom_range(9, 64));
            else if (r < 88)
                n = TABLE_ROWS;
            else if (r < 94)
                n = 0;
            else
                n = int'($urandom_range(65, 127));
            steady = (phase == STEADY_PHASE);
            set_config($urandom_range(0, 9) != 0, n);
            n = rows_in_use();
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                r     = int'($urandom_range(0, 99));
                idx   = stls_pkg::INDEX_W'($urandom_range(0, TABLE_ROWS - 1));
                steps = ($urandom_range(0, 9) == 0)
                        ? stls_pkg::LOAD_STEP_W'($urandom_range(0, 65535))
                        : stls_pkg::LOAD_STEP_W'($urandom_range(0, 5));
                susp  = ($urandom_range(0, 4) == 0);
                if (r < 8)
                    send_request(stls_pkg::CMD_LOAD, idx, steps, susp);
                else if (r < 18)
                begin
                    // mostly a start that lands inside the table
                    if (n > 0 && $urandom_range(0, 5) != 0)
                        idx = stls_pkg::INDEX_W'($urandom_range(0, n - 1));
                    send_request(stls_pkg::CMD_START, idx, steps, susp);
                end
                else if (r < 22)
                    send_request(stls_pkg::CMD_STOP, idx, steps, susp);
                else if (r < 27)
                    send_request(stls_pkg::CMD_PAUSE, idx, steps, susp);
                else if (r < 33)
                    send_request(stls_pkg::CMD_RESUME, idx, steps, susp);
                else if (r < 36)
                    send_request($urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7,
                                 idx, steps, susp);
                else
                    send_request(stls_pkg::CMD_TICK, idx, steps, susp);
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = stls_pkg::CFG_TABLE_PRESENT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        cmd            = stls_pkg::CMD_LOAD;
        row_index      = '0;
        row_total_step = '0;
        row_suspend    = 1'b0;
        out_stall      = 1'b0;
        steady         = 1'b0;
        fail_count     = 0;
        sent_count     = 0;
        checked_count  = 0;
        started_count  = 0;
        dispatch_count = 0;
        cfg_count      = 0;
        idle_cycles    = 0;
        tbl_present    = 1'b0;
        cfg_rows       = 0;
        halt_sequence();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_all_rows();
        test_start_status();
        test_field_extremes();
        test_pause_hold();
        test_last_row();
        test_shrink_rows();
        test_unknown_cmds();
        test_random_traffic();
        drain_results();

        $display("tb_top: %0d requests, %0d results checked, %0d config settings",
                 sent_count, checked_count, cfg_count);
        $display("tb_top: %0d successful starts, %0d dispatching ticks",
                 started_count, dispatch_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
